### design/rdsi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsi_pkg
// Shared constants, register map and pipeline side-band types for the
// receive delay sample index block.
// ----------------------------------------------------------------------------
package rdsi_pkg;

  localparam int MAX_TRACE_LENGTH = 65536;
  localparam int IDX_W            = 17;

  // pipeline depths: one result bit per stage
  localparam int SQ_N = 34;  // square root of the 67-bit sum of squares
  localparam int D1_N = 58;  // (dist << 24) / sound_speed
  localparam int D2_N = 60;  // |t - start| / sample_period

  localparam logic [23:0] SOUND_SPEED_RST   = 24'd394240;
  localparam logic [30:0] SAMPLE_PERIOD_RST = 31'd43980;
  localparam logic [16:0] TRACE_LENGTH_RST  = 17'd65536;

  typedef enum logic [2:0] {
    REG_REF_X         = 3'd0,
    REG_REF_Y         = 3'd1,
    REG_REF_Z         = 3'd2,
    REG_SOUND_SPEED   = 3'd3,
    REG_TIME_OFFSET   = 3'd4,
    REG_START_TIME    = 3'd5,
    REG_SAMPLE_PERIOD = 3'd6,
    REG_TRACE_LENGTH  = 3'd7
  } cfg_reg_t;

  // side-band carried along the front half of the pipe
  typedef struct packed {
    logic signed [31:0] txd;
    logic               mask;
    logic               last;
  } side_t;

  // side-band carried along the back half of the pipe
  typedef struct packed {
    logic neg;
    logic mask;
    logic last;
  } tail_t;

endpackage

### design/rdsi_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdsi_in_if / rdsi_out_if
// Valid/ready channels for field points and sample index results.
// ----------------------------------------------------------------------------
interface rdsi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [31:0] tx_delay;
  logic               mask_in;
  logic               last_point;

  modport source (output valid, point_x, point_y, point_z, tx_delay, mask_in,
                  last_point, input ready);
  modport sink   (input valid, point_x, point_y, point_z, tx_delay, mask_in,
                  last_point, output ready);
endinterface

interface rdsi_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] sample_index;
  logic               mask_out;
  logic               last_out;

  modport source (output valid, sample_index, mask_out, last_out, input ready);
  modport sink   (input valid, sample_index, mask_out, last_out, output ready);
endinterface

### design/receive_delay_sample_index.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// receive_delay_sample_index
// Per field point: distance to the reference point, receive time, total
// delay and trace sample index, fully pipelined.
// ----------------------------------------------------------------------------
// One field point is accepted per clock and one result leaves per clock
// unless the output stalls. The pipe has 3 front stages for differences,
// squares and their sum, 34 square-root stages, 58 stages of the divide by
// sound speed, 2 stages for the time sum and its magnitude, 60 stages of the
// divide by the sample period and 1 output register. Every stage advances
// together: when the output register holds an unaccepted beat the whole pipe
// freezes and in_ch.ready drops, so nothing is lost or repeated. Registers
// are written through the APB port (byte address 4*i, a setup and an access
// phase) and must only change while no point is in flight; the dividers read
// them directly. A sound speed or sample period of zero is used as one, a
// trace length above 65536 is clipped to 65536. Masked points and indices
// outside [0, trace length) give sample_index = -1 with mask_out cleared.
// ----------------------------------------------------------------------------
module receive_delay_sample_index
  import rdsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  rdsi_in_if.sink     in_ch,
  rdsi_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [31:0] ref_x_r, ref_y_r, ref_z_r;
  logic [23:0]        sound_speed_r;
  logic signed [31:0] time_offset_r, start_time_r;
  logic [30:0]        sample_period_r;
  logic [16:0]        trace_length_r;
  cfg_reg_t           reg_sel;

  assign reg_sel = cfg_reg_t'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_x_r         <= '0;
      ref_y_r         <= '0;
      ref_z_r         <= '0;
      sound_speed_r   <= SOUND_SPEED_RST;
      time_offset_r   <= '0;
      start_time_r    <= '0;
      sample_period_r <= SAMPLE_PERIOD_RST;
      trace_length_r  <= TRACE_LENGTH_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_REF_X:         ref_x_r         <= pwdata;
        REG_REF_Y:         ref_y_r         <= pwdata;
        REG_REF_Z:         ref_z_r         <= pwdata;
        REG_SOUND_SPEED:   sound_speed_r   <= pwdata[23:0];
        REG_TIME_OFFSET:   time_offset_r   <= pwdata;
        REG_START_TIME:    start_time_r    <= pwdata;
        REG_SAMPLE_PERIOD: sample_period_r <= pwdata[30:0];
        REG_TRACE_LENGTH:  trace_length_r  <= pwdata[16:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_REF_X:         prdata = ref_x_r;
      REG_REF_Y:         prdata = ref_y_r;
      REG_REF_Z:         prdata = ref_z_r;
      REG_SOUND_SPEED:   prdata = {8'd0, sound_speed_r};
      REG_TIME_OFFSET:   prdata = time_offset_r;
      REG_START_TIME:    prdata = start_time_r;
      REG_SAMPLE_PERIOD: prdata = {1'b0, sample_period_r};
      REG_TRACE_LENGTH:  prdata = {15'd0, trace_length_r};
    endcase
  end

  // effective values: zero divisors act as one, length clipped
  logic [23:0] c_eff;
  logic [30:0] per_eff;
  logic [16:0] len_eff;

  assign c_eff   = (sound_speed_r == '0) ? 24'd1 : sound_speed_r;
  assign per_eff = (sample_period_r == '0) ? 31'd1 : sample_period_r;
  assign len_eff = (trace_length_r > 17'(MAX_TRACE_LENGTH)) ?
                   17'(MAX_TRACE_LENGTH) : trace_length_r;

  // --------------------------------------------------------------------------
  // Global advance: whole pipe moves unless the output beat is stuck
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_r;

  assign en          = out_ch.ready || !out_valid_r;
  assign in_ch.ready = en;

  function automatic logic [32:0] abs_diff(input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  // --------------------------------------------------------------------------
  // Stage A: absolute differences
  // --------------------------------------------------------------------------
  logic        a_v_r;
  logic [32:0] a_d_r [3];
  side_t       a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_v_r <= 1'b0;
    else if (en) a_v_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d_r[0]      <= abs_diff(in_ch.point_x, ref_x_r);
      a_d_r[1]      <= abs_diff(in_ch.point_y, ref_y_r);
      a_d_r[2]      <= abs_diff(in_ch.point_z, ref_z_r);
      a_side_r.txd  <= in_ch.tx_delay;
      a_side_r.mask <= in_ch.mask_in;
      a_side_r.last <= in_ch.last_point;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: squares. |d| <= 2^32, so bit 32 set means the low part is zero
  // and the square is exactly 2^64.
  // --------------------------------------------------------------------------
  logic        b_v_r;
  logic [64:0] b_sq_r [3];
  side_t       b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_v_r <= 1'b0;
    else if (en) b_v_r <= a_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_sq_r[i] <= a_d_r[i][32] ? {1'b1, 64'd0}
                                  : {1'b0, 64'(a_d_r[i][31:0]) * 64'(a_d_r[i][31:0])};
      end
      b_side_r <= a_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: sum of squares (< 3 * 2^64)
  // --------------------------------------------------------------------------
  logic        c_v_r;
  logic [66:0] c_sum_r;
  side_t       c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_v_r <= 1'b0;
    else if (en) c_v_r <= b_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_sum_r  <= {2'b0, b_sq_r[0]} + {2'b0, b_sq_r[1]} + {2'b0, b_sq_r[2]};
      c_side_r <= b_side_r;
    end
  end

  // --------------------------------------------------------------------------
  // Square root, one root bit per stage (restoring digit recurrence)
  // --------------------------------------------------------------------------
  logic [SQ_N-1:0] sq_v_r;
  logic [67:0]     sq_x_r    [SQ_N];
  logic [34:0]     sq_rem_r  [SQ_N];
  logic [33:0]     sq_root_r [SQ_N];
  side_t           sq_side_r [SQ_N];

  logic [67:0]     sq_x_nxt    [SQ_N];
  logic [34:0]     sq_rem_nxt  [SQ_N];
  logic [33:0]     sq_root_nxt [SQ_N];

  always_comb begin
    logic [67:0] xi;
    logic [34:0] ri;
    logic [33:0] rti;
    logic [36:0] rsh;
    logic [36:0] trial;
    logic        ge;
    for (int k = 0; k < SQ_N; k++) begin
      if (k == 0) begin
        xi  = {1'b0, c_sum_r};
        ri  = '0;
        rti = '0;
      end else begin
        xi  = sq_x_r[(k == 0) ? 0 : k - 1];
        ri  = sq_rem_r[(k == 0) ? 0 : k - 1];
        rti = sq_root_r[(k == 0) ? 0 : k - 1];
      end
      rsh            = {ri, xi[67:66]};
      trial          = {1'b0, rti, 2'b01};
      ge             = (rsh >= trial);
      sq_x_nxt[k]    = {xi[65:0], 2'b00};
      sq_rem_nxt[k]  = ge ? 35'(rsh - trial) : rsh[34:0];
      sq_root_nxt[k] = {rti[32:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r <= '0;
    else if (en) sq_v_r <= {sq_v_r[SQ_N-2:0], c_v_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < SQ_N; k++) begin
        sq_x_r[k]    <= sq_x_nxt[k];
        sq_rem_r[k]  <= sq_rem_nxt[k];
        sq_root_r[k] <= sq_root_nxt[k];
        sq_side_r[k] <= (k == 0) ? c_side_r : sq_side_r[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receive time: (dist << 24) / c, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [D1_N-1:0] d1_v_r;
  logic [57:0]     d1_d_r    [D1_N];
  logic [23:0]     d1_rem_r  [D1_N];
  logic [57:0]     d1_q_r    [D1_N];
  side_t           d1_side_r [D1_N];

  logic [57:0]     d1_d_nxt   [D1_N];
  logic [23:0]     d1_rem_nxt [D1_N];
  logic [57:0]     d1_q_nxt   [D1_N];

  always_comb begin
    logic [57:0] di;
    logic [23:0] ri;
    logic [57:0] qi;
    logic [24:0] rsh;
    logic        ge;
    for (int j = 0; j < D1_N; j++) begin
      if (j == 0) begin
        di = {sq_root_r[SQ_N-1], 24'd0};
        ri = '0;
        qi = '0;
      end else begin
        di = d1_d_r[(j == 0) ? 0 : j - 1];
        ri = d1_rem_r[(j == 0) ? 0 : j - 1];
        qi = d1_q_r[(j == 0) ? 0 : j - 1];
      end
      rsh           = {ri, di[57]};
      ge            = (rsh >= {1'b0, c_eff});
      d1_d_nxt[j]   = {di[56:0], 1'b0};
      d1_rem_nxt[j] = ge ? 24'(rsh - {1'b0, c_eff}) : rsh[23:0];
      d1_q_nxt[j]   = {qi[56:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r <= '0;
    else if (en) d1_v_r <= {d1_v_r[D1_N-2:0], sq_v_r[SQ_N-1]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < D1_N; j++) begin
        d1_d_r[j]    <= d1_d_nxt[j];
        d1_rem_r[j]  <= d1_rem_nxt[j];
        d1_q_r[j]    <= d1_q_nxt[j];
        d1_side_r[j] <= (j == 0) ? sq_side_r[SQ_N-1]
                                 : d1_side_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Total time relative to start, then sign and magnitude
  // --------------------------------------------------------------------------
  logic               t1_v_r;
  logic signed [59:0] t1_sum_r;
  logic               t1_mask_r, t1_last_r;
  side_t              d1_out;

  assign d1_out = d1_side_r[D1_N-1];

  always_ff @(posedge clk) begin
    if (!rst_n) t1_v_r <= 1'b0;
    else if (en) t1_v_r <= d1_v_r[D1_N-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_sum_r  <= $signed({2'b00, d1_q_r[D1_N-1]})
                 + $signed({{28{d1_out.txd[31]}}, d1_out.txd})
                 + $signed({{28{time_offset_r[31]}}, time_offset_r})
                 - $signed({{28{start_time_r[31]}}, start_time_r});
      t1_mask_r <= d1_out.mask;
      t1_last_r <= d1_out.last;
    end
  end

  logic        t2_v_r;
  logic [59:0] t2_mag_r;
  tail_t       t2_tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) t2_v_r <= 1'b0;
    else if (en) t2_v_r <= t1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_mag_r       <= t1_sum_r[59] ? 60'(-t1_sum_r) : 60'(t1_sum_r);
      t2_tail_r.neg  <= t1_sum_r[59];
      t2_tail_r.mask <= t1_mask_r;
      t2_tail_r.last <= t1_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Index magnitude: |t| / period, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [D2_N-1:0] d2_v_r;
  logic [59:0]     d2_d_r    [D2_N];
  logic [30:0]     d2_rem_r  [D2_N];
  logic [59:0]     d2_q_r    [D2_N];
  tail_t           d2_tail_r [D2_N];

  logic [59:0]     d2_d_nxt   [D2_N];
  logic [30:0]     d2_rem_nxt [D2_N];
  logic [59:0]     d2_q_nxt   [D2_N];

  always_comb begin
    logic [59:0] di;
    logic [30:0] ri;
    logic [59:0] qi;
    logic [31:0] rsh;
    logic        ge;
    for (int j = 0; j < D2_N; j++) begin
      if (j == 0) begin
        di = t2_mag_r;
        ri = '0;
        qi = '0;
      end else begin
        di = d2_d_r[(j == 0) ? 0 : j - 1];
        ri = d2_rem_r[(j == 0) ? 0 : j - 1];
        qi = d2_q_r[(j == 0) ? 0 : j - 1];
      end
      rsh           = {ri, di[59]};
      ge            = (rsh >= {1'b0, per_eff});
      d2_d_nxt[j]   = {di[58:0], 1'b0};
      d2_rem_nxt[j] = ge ? 31'(rsh - {1'b0, per_eff}) : rsh[30:0];
      d2_q_nxt[j]   = {qi[58:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d2_v_r <= '0;
    else if (en) d2_v_r <= {d2_v_r[D2_N-2:0], t2_v_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < D2_N; j++) begin
        d2_d_r[j]    <= d2_d_nxt[j];
        d2_rem_r[j]  <= d2_rem_nxt[j];
        d2_q_r[j]    <= d2_q_nxt[j];
        d2_tail_r[j] <= (j == 0) ? t2_tail_r : d2_tail_r[(j == 0) ? 0 : j - 1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register: range check and -1 substitution. A negative time gives
  // a non-negative index only when it is within one period of start (index 0).
  // --------------------------------------------------------------------------
  logic [59:0]      qf;
  tail_t            tf;
  logic             idx_ok;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_mask_r, out_last_r;

  assign qf     = d2_q_r[D2_N-1];
  assign tf     = d2_tail_r[D2_N-1];
  assign idx_ok = tf.mask && (qf < {43'd0, len_eff}) && (!tf.neg || qf == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= d2_v_r[D2_N-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_idx_r  <= idx_ok ? qf[IDX_W-1:0] : '1;
      out_mask_r <= idx_ok;
      out_last_r <= tf.last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.sample_index = out_idx_r;
  assign out_ch.mask_out     = out_mask_r;
  assign out_ch.last_out     = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_mask_matches_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_mask_r == (out_idx_r != '1)))
    else $error("mask_out disagrees with sample_index");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_mask_r |-> (out_idx_r < len_eff))
    else $error("valid sample_index beyond trace length");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(sq_v_r) && $stable(d1_v_r) && $stable(d2_v_r))
    else $error("pipeline moved during output stall");

  a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(out_idx_r) && $stable(out_last_r))
    else $error("output beat changed while stalled");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for receive_delay_sample_index: field points are driven
// through the input channel, expected sample indices are computed by an
// independent distance/time/index predictor and compared against every
// result beat. Registers are swept through several settings over APB.
// ----------------------------------------------------------------------------
module tb_top;
  import rdsi_pkg::*;

  localparam int LATENCY = 158;
  localparam longint LIMIT = 1_000_000;

  typedef struct packed {
    logic signed [16:0] idx;
    logic               mask;
    logic               last;
  } index_beat_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  rdsi_in_if  in_ch();
  rdsi_out_if out_ch();

  receive_delay_sample_index u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // shadow copy of the register file, used by the predictor
  logic signed [31:0] sh_ref_x, sh_ref_y, sh_ref_z, sh_toff, sh_start;
  logic [23:0] sh_speed;
  logic [30:0] sh_period;
  logic [16:0] sh_len;

  index_beat_t expected_idx_q[$];
  int  mismatches;
  int  beats_checked;
  int  valid_seen;
  int  send_idle_pct;
  int  recv_stall_pct;
  longint cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic logic [33:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [33:0] d;
    d = 34'(a) - 34'(b);
    return d < 0 ? 34'(-d) : 34'(d);
  endfunction

  // floor(sqrt(s)) for s below 2^68, one result bit per pass
  function automatic logic [33:0] floor_sqrt(logic [67:0] s);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if (68'(c) * 68'(c) <= s) r = c;
    end
    return r;
  endfunction

  function automatic index_beat_t predict_index(logic signed [31:0] px, logic signed [31:0] py,
                                                logic signed [31:0] pz, logic signed [31:0] txd,
                                                logic mask, logic last);
    logic [33:0] dx, dy, dz, d_root;
    logic [67:0] sumsq;
    logic [63:0] spd, trx;
    logic signed [63:0] t, per, q, len;
    index_beat_t r;
    dx = abs_diff(px, sh_ref_x);
    dy = abs_diff(py, sh_ref_y);
    dz = abs_diff(pz, sh_ref_z);
    sumsq = 68'(dx) * 68'(dx) + 68'(dy) * 68'(dy) + 68'(dz) * 68'(dz);
    d_root = floor_sqrt(sumsq);
    spd = (sh_speed == 0) ? 64'd1 : 64'(sh_speed);
    trx = (64'(d_root) << 24) / spd;
    t = $signed(trx) + 64'(txd) + 64'(sh_toff);
    per = (sh_period == 0) ? 64'sd1 : $signed(64'(sh_period));
    q = (t - 64'(sh_start)) / per;
    len = $signed(64'(sh_len));
    if (len > MAX_TRACE_LENGTH) len = MAX_TRACE_LENGTH;
    r.last = last;
    if (mask && q >= 0 && q < len) begin
      r.idx  = 17'(q);
      r.mask = 1'b1;
    end else begin
      r.idx  = '1;
      r.mask = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("mismatch at beat %0d: %s got %0d expected %0d", beats_checked, what, got, want);
  endtask

  // result checker, also drives the receiver stall pattern
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        index_beat_t exp_b;
        if (expected_idx_q.size() == 0) begin
          report_mismatch("unexpected beat, index", out_ch.sample_index, 0);
        end else begin
          exp_b = expected_idx_q.pop_front();
          if (out_ch.sample_index !== exp_b.idx)
            report_mismatch("sample_index", out_ch.sample_index, exp_b.idx);
          if (out_ch.mask_out !== exp_b.mask)
            report_mismatch("mask_out", out_ch.mask_out, exp_b.mask);
          if (out_ch.last_out !== exp_b.last)
            report_mismatch("last_out", out_ch.last_out, exp_b.last);
          if (exp_b.mask) valid_seen++;
        end
        beats_checked++;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(r) << 2;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_REF_X:         sh_ref_x  = v;
      REG_REF_Y:         sh_ref_y  = v;
      REG_REF_Z:         sh_ref_z  = v;
      REG_SOUND_SPEED:   sh_speed  = v[23:0];
      REG_TIME_OFFSET:   sh_toff   = v;
      REG_START_TIME:    sh_start  = v;
      REG_SAMPLE_PERIOD: sh_period = v[30:0];
      REG_TRACE_LENGTH:  sh_len    = v[16:0];
      default: ;
    endcase
  endtask

  // one point per call, starting at a clock edge; returns at the accepting
  // edge with valid still high so the next call can follow without a gap
  task automatic send_point(logic signed [31:0] px, logic signed [31:0] py,
                            logic signed [31:0] pz, logic signed [31:0] txd,
                            logic mask, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.point_x    <= px;
    in_ch.point_y    <= py;
    in_ch.point_z    <= pz;
    in_ch.tx_delay   <= txd;
    in_ch.mask_in    <= mask;
    in_ch.last_point <= last;
    expected_idx_q.push_back(predict_index(px, py, pz, txd, mask, last));
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // ends a burst: valid drops, then every result is collected
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_idx_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
  endtask

  // random point near the reference so indices land in range often
  task automatic send_random_point();
    logic signed [31:0] px, py, pz, txd;
    if ($urandom_range(3) == 0) begin
      px = $urandom; py = $urandom; pz = $urandom; txd = $urandom;
    end else begin
      px  = sh_ref_x + $signed(32'($urandom_range(33554432)) - 32'sd16777216);
      py  = sh_ref_y + $signed(32'($urandom_range(33554432)) - 32'sd16777216);
      pz  = sh_ref_z + $signed(32'($urandom_range(8388608)));
      txd = $signed(32'($urandom_range(200000000)) - 32'sd50000000);
    end
    send_point(px, py, pz, txd, $urandom_range(7) != 0, $urandom_range(15) == 0);
  endtask

  task automatic test_defaults_directed();
    send_point(0, 0, 0, 0, 1'b1, 1'b0);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b1, 1'b1);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1, 1'b0);
    send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 1'b1, 1'b0);
    send_point(0, 0, 32'h01000000, 0, 1'b1, 1'b0);     // 1 m straight ahead
    send_point(0, 0, 32'h01000000, 0, 1'b0, 1'b1);     // masked point
    send_point(0, 0, 0, -32'sd1, 1'b1, 1'b0);          // just below start: index 0
    send_point(0, 0, 0, -32'sd43980, 1'b1, 1'b0);      // one period below: -1
    send_point(0, 0, 0, 32'sd43979, 1'b1, 1'b0);
    send_point(0, 0, 0, 32'sd43980, 1'b1, 1'b0);
    send_point(32'h55555555, 32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_degenerate_registers();
    // zero speed and period act as one, zero length rejects everything
    write_reg(REG_SOUND_SPEED, 32'd0);
    write_reg(REG_SAMPLE_PERIOD, 32'd0);
    write_reg(REG_TRACE_LENGTH, 32'h0001ffff);          // clipped to max
    send_point(0, 0, 32'd3, 0, 1'b1, 1'b0);
    send_point(0, 0, 0, 32'sd65535, 1'b1, 1'b0);
    send_point(0, 0, 0, 32'sd65536, 1'b1, 1'b0);
    drain();
    write_reg(REG_TRACE_LENGTH, 32'd0);
    send_point(0, 0, 0, 0, 1'b1, 1'b0);
    drain();
    write_reg(REG_TRACE_LENGTH, 32'd1);
    write_reg(REG_SAMPLE_PERIOD, 32'h7fffffff);
    write_reg(REG_SOUND_SPEED, 32'h00ffffff);
    send_point(0, 0, 0, 32'h7fffffff, 1'b1, 1'b0);
    send_point(0, 0, 0, 32'h80000000, 1'b1, 1'b1);
    drain();
  endtask

  task automatic test_random_settings(int n_cfgs, int per_cfg);
    for (int c = 0; c < n_cfgs; c++) begin
      write_reg(REG_REF_X, (c % 3 == 0) ? 32'h80000000 : $urandom);
      write_reg(REG_REF_Y, (c % 3 == 1) ? 32'h7fffffff : $urandom_range(100000000));
      write_reg(REG_REF_Z, $urandom_range(16777216));
      write_reg(REG_SOUND_SPEED, (c == 0) ? 32'd1 : $urandom_range(400000, 300000));
      write_reg(REG_TIME_OFFSET, (c == 1) ? 32'h80000000 : $urandom);
      write_reg(REG_START_TIME, (c == 2) ? 32'h7fffffff : $urandom_range(10000000));
      write_reg(REG_SAMPLE_PERIOD, (c == 3) ? 32'd1 : $urandom_range(80000, 100));
      write_reg(REG_TRACE_LENGTH, (c == 4) ? 32'd65536 : $urandom_range(65536, 1));
      for (int i = 0; i < per_cfg; i++) send_random_point();
      drain();
    end
  endtask

  initial begin
    int n_sent;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.point_x = '0; in_ch.point_y = '0; in_ch.point_z = '0;
    in_ch.tx_delay = '0; in_ch.mask_in = 1'b0; in_ch.last_point = 1'b0;
    mismatches = 0; beats_checked = 0; valid_seen = 0;
    send_idle_pct = 20; recv_stall_pct = 74;
    sh_ref_x = 0; sh_ref_y = 0; sh_ref_z = 0; sh_toff = 0; sh_start = 0;
    sh_speed = SOUND_SPEED_RST; sh_period = SAMPLE_PERIOD_RST; sh_len = TRACE_LENGTH_RST;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_defaults_directed();
    test_degenerate_registers();
    test_random_settings(8, 60);        // sender busy, receiver stalls hard
    send_idle_pct = 74; recv_stall_pct = 20;
    test_random_settings(8, 60);
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random_settings(8, 60);

    $display("covered %0d result beats, %0d with an in-range index", beats_checked, valid_seen);
    $display("register sweeps: defaults, degenerate values and 24 random settings");
    if (mismatches == 0 && expected_idx_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
